/* hw/rtl/gphrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gphrt_pkg;

  // default number of buttons; sources are buttons, two sticks, two triggers
  localparam int NumButtonsDef = 16;

  localparam int SrcW = 5;
  localparam logic [14:0] DeadzoneRst = 15'd8000;
  localparam logic [7:0] ControllerIdRst = 8'd0;

  // configuration register indexes
  localparam logic RegDeadzone = 1'b0;
  localparam logic RegControllerId = 1'b1;

  // item kinds
  localparam logic [1:0] KindButton = 2'd0;
  localparam logic [1:0] KindAxis = 2'd1;
  localparam logic [1:0] KindScan = 2'd2;

  // press states
  localparam logic [1:0] PsNone = 2'd0;
  localparam logic [1:0] PsPressed = 2'd1;
  localparam logic [1:0] PsHeld = 2'd2;
  localparam logic [1:0] PsReleased = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         button;
    logic               pressed;
    logic [2:0]         axis;
    logic signed [15:0] axis_value;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [SrcW-1:0]    source;
    logic [1:0]         press_state;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [15:0] trigger_value;
    logic [31:0]        duration_ms;
    logic [7:0]         owner;
    logic               last;
  } out_item_t;

  // microcode
  localparam int StepW = 3;
  localparam logic [StepW-1:0] StepFetch = 3'd0;
  localparam logic [StepW-1:0] StepButton = 3'd1;
  localparam logic [StepW-1:0] StepAxis = 3'd2;
  localparam logic [StepW-1:0] StepScan = 3'd3;
  localparam logic [StepW-1:0] StepFlush = 3'd4;
  localparam logic [StepW-1:0] StepLast = StepFlush;

  typedef enum logic [2:0] {
    OpFetch  = 3'd0,
    OpButton = 3'd1,
    OpAxis   = 3'd2,
    OpScan   = 3'd3,
    OpFlush  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    JmpKind    = 2'd0,
    JmpAlways  = 2'd1,
    JmpScanEnd = 2'd2
  } jmp_e;

  typedef struct packed {
    logic             accept;
    op_e              op;
    jmp_e             jmp;
    logic [StepW-1:0] target;
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t cw;
    unique case (step)
      StepFetch:  cw = '{accept: 1'b1, op: OpFetch,  jmp: JmpKind,    target: StepFetch};
      StepButton: cw = '{accept: 1'b0, op: OpButton, jmp: JmpAlways,  target: StepFetch};
      StepAxis:   cw = '{accept: 1'b0, op: OpAxis,   jmp: JmpAlways,  target: StepFetch};
      StepScan:   cw = '{accept: 1'b0, op: OpScan,   jmp: JmpScanEnd, target: StepFlush};
      StepFlush:  cw = '{accept: 1'b0, op: OpFlush,  jmp: JmpAlways,  target: StepFetch};
      default:    cw = '{accept: 1'b0, op: OpFetch,  jmp: JmpAlways,  target: StepFetch};
    endcase
    return cw;
  endfunction

  // dispatch table on item kind
  function automatic logic [StepW-1:0] kind_target(input logic [1:0] kind);
    logic [StepW-1:0] t;
    unique case (kind)
      KindButton: t = StepButton;
      KindAxis:   t = StepAxis;
      KindScan:   t = StepScan;
      default:    t = StepFetch;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gamepad_press_hold_release_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// button and axis items: accepted, then one apply step, no result
// frame-end item: accepted, then one scan step per source, then flush;
//   the result side can stall the scan and flush steps
// a result moves to the output at the next emitting source or at the flush step
// rate is set by the scan step, one source per cycle unless the result side stalls it
// reset: all sources none, no marks, stamps and axis values zero, registers at defaults

module gamepad_press_hold_release_tracker_unit #(
  parameter int NumButtons = gphrt_pkg::NumButtonsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // item input
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  gphrt_pkg::in_item_t   in_item_i,
  // result output
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output gphrt_pkg::out_item_t  out_item_o,
  // configuration port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int NumSrc = NumButtons + 4;
  localparam int IdxW = $clog2(NumSrc);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSrc - 1);
  localparam logic [IdxW-1:0] LStickIdx = IdxW'(NumButtons);
  localparam logic [IdxW-1:0] RStickIdx = IdxW'(NumButtons + 1);
  localparam logic [IdxW-1:0] LTrigIdx = IdxW'(NumButtons + 2);
  localparam logic [IdxW-1:0] RTrigIdx = IdxW'(NumButtons + 3);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [14:0] dz_q;
  logic [7:0]  cid_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q  <= gphrt_pkg::DeadzoneRst;
      cid_q <= gphrt_pkg::ControllerIdRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        gphrt_pkg::RegDeadzone:     dz_q  <= pwdata[14:0];
        gphrt_pkg::RegControllerId: cid_q <= pwdata[7:0];
        default:                    dz_q  <= dz_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gphrt_pkg::RegDeadzone:     prdata = {17'd0, dz_q};
      gphrt_pkg::RegControllerId: prdata = {24'd0, cid_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: step counter addresses the control store
  // ---------------------------------------------------------------------------
  logic [gphrt_pkg::StepW-1:0] step_q, step_d;
  gphrt_pkg::ctrl_t            cw;
  logic                        accept;
  logic                        hold;     // result side full, freeze this step
  logic [IdxW-1:0]             idx_q, idx_d;
  logic                        scan_end;

  assign cw         = gphrt_pkg::ucode(step_q);
  assign in_stall_o = !cw.accept;
  assign accept     = in_valid_i && cw.accept;
  assign scan_end   = (idx_q == LastIdx);

  always_comb begin
    step_d = step_q;
    if (!hold) begin
      unique case (cw.jmp)
        gphrt_pkg::JmpKind:    step_d = accept ? gphrt_pkg::kind_target(in_item_i.kind) : step_q;
        gphrt_pkg::JmpAlways:  step_d = cw.target;
        gphrt_pkg::JmpScanEnd: step_d = scan_end ? cw.target : step_q;
        default:               step_d = gphrt_pkg::StepFetch;
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cw.op == gphrt_pkg::OpFetch) begin
      idx_d = '0;
    end else if (cw.op == gphrt_pkg::OpScan && !hold) begin
      idx_d = scan_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gphrt_pkg::StepFetch;
      idx_q  <= '0;
    end else begin
      step_q <= step_d;
      idx_q  <= idx_d;
    end
  end

  // accepted item is held for the steps that follow
  gphrt_pkg::in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // event datapath
  // ---------------------------------------------------------------------------
  logic            btn_ok;
  logic [IdxW-1:0] btn_src;
  logic [16:0]     ax_ext, ax_mag;
  logic [15:0]     ax_val;
  logic            ax_ok;
  logic            ax_is_trig;
  logic [IdxW-1:0] ax_src;

  assign btn_ok  = int'(item_q.button) < NumButtons;
  assign btn_src = IdxW'(item_q.button);

  // magnitude in 17 bits so the full-scale negative reading stays positive
  assign ax_ext     = {item_q.axis_value[15], item_q.axis_value};
  assign ax_mag     = ax_ext[16] ? (17'd0 - ax_ext) : ax_ext;
  assign ax_val     = (ax_mag > {2'b00, dz_q}) ? item_q.axis_value : 16'd0;
  assign ax_ok      = (item_q.axis < 3'd6);
  assign ax_is_trig = item_q.axis[2];
  assign ax_src     = ax_is_trig ? (item_q.axis[0] ? RTrigIdx : LTrigIdx)
                                 : (item_q.axis[1] ? RStickIdx : LStickIdx);

  // ---------------------------------------------------------------------------
  // per-source state
  // ---------------------------------------------------------------------------
  logic [1:0]  st_q    [NumSrc];
  logic [31:0] stamp_q [NumSrc];
  logic [NumSrc-1:0] mark_q;
  logic [15:0] sx_q [2];
  logic [15:0] sy_q [2];
  logic [15:0] tv_q [2];

  // scan step: read the visited source and work out its next state
  logic            upd;
  logic [1:0]      st_cur, st_new;
  logic            is_stick, is_trig, sel;
  logic [IdxW-1:0] off;
  logic [15:0]     sx, sy, tv;
  logic            active, was_on;
  logic [31:0]     dur;
  logic            emit;

  assign upd      = mark_q[idx_q];
  assign st_cur   = st_q[idx_q];
  assign is_stick = (idx_q == LStickIdx) || (idx_q == RStickIdx);
  assign is_trig  = (idx_q == LTrigIdx) || (idx_q == RTrigIdx);
  assign off      = idx_q - LStickIdx;
  assign sel      = off[0];
  assign sx       = is_stick ? sx_q[sel] : 16'd0;
  assign sy       = is_stick ? sy_q[sel] : 16'd0;
  assign tv       = is_trig ? tv_q[sel] : 16'd0;
  assign active   = is_stick ? ((sx != 16'd0) || (sy != 16'd0)) : (tv != 16'd0);
  assign was_on   = (st_cur == gphrt_pkg::PsPressed) || (st_cur == gphrt_pkg::PsHeld);
  assign dur      = upd ? 32'd0 : (item_q.time_ms - stamp_q[idx_q]);

  always_comb begin
    st_new = st_cur;
    priority if (!upd) begin
      // not touched this frame: keep holding, otherwise fall back to none
      st_new = was_on ? gphrt_pkg::PsHeld : gphrt_pkg::PsNone;
    end else if (is_stick || is_trig) begin
      if (active) begin
        st_new = was_on ? gphrt_pkg::PsHeld : gphrt_pkg::PsPressed;
      end else begin
        st_new = was_on ? gphrt_pkg::PsReleased : gphrt_pkg::PsNone;
      end
    end else begin
      // updated button keeps what its event set
      st_new = st_cur;
    end
  end

  assign emit = (st_new != gphrt_pkg::PsNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSrc; i++) begin
        st_q[i]    <= gphrt_pkg::PsNone;
        stamp_q[i] <= '0;
      end
      mark_q <= '0;
      for (int i = 0; i < 2; i++) begin
        sx_q[i] <= '0;
        sy_q[i] <= '0;
        tv_q[i] <= '0;
      end
    end else begin
      unique case (cw.op)
        gphrt_pkg::OpButton: begin
          if (btn_ok) begin
            st_q[btn_src]    <= item_q.pressed ? gphrt_pkg::PsPressed
                                               : gphrt_pkg::PsReleased;
            mark_q[btn_src]  <= 1'b1;
            stamp_q[btn_src] <= item_q.time_ms;
          end
        end
        gphrt_pkg::OpAxis: begin
          if (ax_ok) begin
            priority if (ax_is_trig) begin
              tv_q[item_q.axis[0]] <= ax_val;
            end else if (item_q.axis[0]) begin
              sy_q[item_q.axis[1]] <= ax_val;
            end else begin
              sx_q[item_q.axis[1]] <= ax_val;
            end
            mark_q[ax_src]  <= 1'b1;
            stamp_q[ax_src] <= item_q.time_ms;
          end
        end
        gphrt_pkg::OpScan: begin
          if (!hold) begin
            st_q[idx_q] <= st_new;
          end
        end
        gphrt_pkg::OpFlush: begin
          if (!hold) begin
            mark_q <= '0;
          end
        end
        default: begin
          mark_q <= mark_q;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result path: one pending slot so the final result can carry last,
  // then the output register
  // ---------------------------------------------------------------------------
  gphrt_pkg::out_item_t res, pend_q, out_q, fin;
  logic                 pend_valid_q, out_valid_q;
  logic                 out_busy, move;
  logic                 is_scan, is_flush;

  assign is_scan  = (cw.op == gphrt_pkg::OpScan);
  assign is_flush = (cw.op == gphrt_pkg::OpFlush);
  assign out_busy = out_valid_q && out_stall_i;
  assign hold     = pend_valid_q && out_busy && ((is_scan && emit) || is_flush);
  assign move     = pend_valid_q && !hold && ((is_scan && emit) || is_flush);

  always_comb begin
    res.source        = gphrt_pkg::SrcW'(idx_q);
    res.press_state   = st_new;
    res.stick_x       = sx;
    res.stick_y       = sy;
    res.trigger_value = tv;
    res.duration_ms   = dur;
    res.owner         = cid_q;
    res.last          = 1'b0;
  end

  // only the flush step drains the final result of the scan
  always_comb begin
    fin      = pend_q;
    fin.last = is_flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (is_scan && emit && !hold) begin
        pend_valid_q <= 1'b1;
      end else if (is_flush && !hold) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_scan && emit && !hold) begin
      pend_q <= res;
    end
    if (move) begin
      out_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fetch_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == gphrt_pkg::OpFetch) |-> !pend_valid_q)
    else $error("pending result left over when taking a new item");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("scan index out of range");

  a_marks_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_flush && !hold) |=> (mark_q == '0))
    else $error("update marks not cleared after scan");

  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= gphrt_pkg::StepLast)
    else $error("step counter outside control store");

endmodule

`default_nettype wire

/* test/gphrt_tracker_checker.sv */
`timescale 1ns / 1ps

module gphrt_tracker_checker
  import gphrt_pkg::*;
#(
  parameter int NumButtons = NumButtonsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam int NumSources = NumButtons + 4;
  localparam int SrcLeftStick = NumButtons;
  localparam int SrcRightStick = NumButtons + 1;
  localparam int SrcLeftTrigger = NumButtons + 2;
  localparam int SrcRightTrigger = NumButtons + 3;
  localparam logic [2:0] AddrDeadzone = {RegDeadzone, 2'b00};
  localparam logic [2:0] AddrControllerId = {RegControllerId, 2'b00};

  logic [1:0]         press_of [NumSources];
  bit                 touched [NumSources];
  logic [31:0]        stamp_of [NumSources];
  logic signed [15:0] stick_x_of [2];
  logic signed [15:0] stick_y_of [2];
  logic signed [15:0] trig_of [2];
  logic [14:0]        deadzone_q;
  logic [7:0]         owner_q;

  out_item_t expected_events[$];
  out_item_t want;
  int        err_count;

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      err_count++;
      $display("%0t: %s mismatch on source %0d, expected %0h, got %0h",
               $time, what, want.source, exp_v, got_v);
    end
  endtask

  // advance the tracker state by one item, queueing any events it emits
  task automatic track_item(input in_item_t it);
    int                 raw;
    int                 mag;
    int                 s;
    logic signed [15:0] kept;
    logic [1:0]         st;
    logic [31:0]        dur;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] tv;
    bit                 is_stick;
    bit                 is_trig;
    bit                 active;
    bit                 have_held;
    out_item_t          held_back;
    have_held = 1'b0;
    held_back = '0;
    case (it.kind)
      KindButton: begin
        if (int'(it.button) < NumButtons) begin
          press_of[it.button] = it.pressed ? PsPressed : PsReleased;
          touched[it.button] = 1'b1;
          stamp_of[it.button] = it.time_ms;
        end
      end
      KindAxis: begin
        raw = it.axis_value;
        mag = (raw < 0) ? -raw : raw;
        kept = (mag > int'(deadzone_q)) ? it.axis_value : 16'sd0;
        // axis codes 6 and 7 have both upper bits set
        if (!(it.axis[2] && it.axis[1])) begin
          if (it.axis[2]) begin
            s = SrcLeftTrigger + int'(it.axis[0]);
            trig_of[it.axis[0]] = kept;
          end else begin
            s = SrcLeftStick + int'(it.axis[1]);
            if (it.axis[0]) stick_y_of[it.axis[1]] = kept;
            else stick_x_of[it.axis[1]] = kept;
          end
          touched[s] = 1'b1;
          stamp_of[s] = it.time_ms;
        end
      end
      KindScan: begin
        for (int i = 0; i < NumSources; i++) begin
          st = press_of[i];
          dur = '0;
          sx = '0;
          sy = '0;
          tv = '0;
          is_stick = (i == SrcLeftStick) || (i == SrcRightStick);
          is_trig = (i == SrcLeftTrigger) || (i == SrcRightTrigger);
          if (is_stick) begin
            sx = stick_x_of[i - SrcLeftStick];
            sy = stick_y_of[i - SrcLeftStick];
          end else if (is_trig) begin
            tv = trig_of[i - SrcLeftTrigger];
          end
          if (!touched[i]) begin
            dur = it.time_ms - stamp_of[i];
            st = (st == PsPressed || st == PsHeld) ? PsHeld : PsNone;
          end else if (is_stick || is_trig) begin
            active = is_stick ? (sx != 0 || sy != 0) : (tv != 0);
            if (active) st = (st == PsNone || st == PsReleased) ? PsPressed : PsHeld;
            else st = (st == PsPressed || st == PsHeld) ? PsReleased : PsNone;
          end
          press_of[i] = st;
          if (st != PsNone) begin
            if (have_held) expected_events.push_back(held_back);
            held_back = '{source: SrcW'(i), press_state: st, stick_x: sx, stick_y: sy,
                          trigger_value: tv, duration_ms: dur, owner: owner_q, last: 1'b0};
            have_held = 1'b1;
          end
        end
        for (int i = 0; i < NumSources; i++) touched[i] = 1'b0;
        if (have_held) begin
          held_back.last = 1'b1;
          expected_events.push_back(held_back);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSources; i++) begin
        press_of[i] = PsNone;
        touched[i] = 1'b0;
        stamp_of[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
        stick_x_of[i] = '0;
        stick_y_of[i] = '0;
        trig_of[i] = '0;
      end
      deadzone_q = DeadzoneRst;
      owner_q = ControllerIdRst;
      expected_events.delete();
      err_count = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == AddrDeadzone) deadzone_q = pwdata_i[14:0];
        else if (paddr_i == AddrControllerId) owner_q = pwdata_i[7:0];
      end
      // results first: a result can never belong to a scan taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got source %0d state %0d",
                   $time, out_item_i.source, out_item_i.press_state);
        end else begin
          want = expected_events.pop_front();
          check_field("source", want.source, out_item_i.source);
          check_field("press_state", want.press_state, out_item_i.press_state);
          check_field("stick_x", want.stick_x, out_item_i.stick_x);
          check_field("stick_y", want.stick_y, out_item_i.stick_y);
          check_field("trigger_value", want.trigger_value, out_item_i.trigger_value);
          check_field("duration_ms", want.duration_ms, out_item_i.duration_ms);
          check_field("owner", want.owner, out_item_i.owner);
          check_field("last", want.last, out_item_i.last);
        end
      end
      if (in_valid_i && !in_stall_i) track_item(in_item_i);
      mismatches_o <= err_count;
      pending_o <= expected_events.size();
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import gphrt_pkg::*;

  // register map, one 32-bit word per register
  localparam logic [2:0] AddrDeadzone = {RegDeadzone, 2'b00};
  localparam logic [2:0] AddrControllerId = {RegControllerId, 2'b00};

  // item codes the package leaves unnamed
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [2:0] AxisLeftX = 3'd0;
  localparam logic [2:0] AxisLeftY = 3'd1;
  localparam logic [2:0] AxisRightX = 3'd2;
  localparam logic [2:0] AxisRightY = 3'd3;
  localparam logic [2:0] AxisLeftTrig = 3'd4;
  localparam logic [2:0] AxisRightTrig = 3'd5;
  localparam logic [2:0] AxisBadLow = 3'd6;
  localparam logic [2:0] AxisBadHigh = 3'd7;

  // idle wait after the last expected event so a late scan can finish
  localparam int DrainCycles = 40;
  localparam int HoldCycles = 400;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems = 36;
  localparam int PressureItems = 25;
  localparam int DirDeadzone = 1000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic [14:0] dz_now = DeadzoneRst;
  logic [31:0] clock_ms = '0;
  int          quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gamepad_press_hold_release_tracker_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  gphrt_tracker_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // every field random, so unused fields still toggle
  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind = 2'($urandom);
    it.button = 4'($urandom);
    it.pressed = 1'($urandom);
    it.axis = 3'($urandom);
    it.axis_value = 16'($urandom);
    it.time_ms = $urandom;
    return it;
  endfunction

  function automatic in_item_t button_item(input logic [3:0] b, input logic p,
                                           input logic [31:0] t);
    in_item_t it;
    it = noise_item();
    it.kind = KindButton;
    it.button = b;
    it.pressed = p;
    it.time_ms = t;
    return it;
  endfunction

  function automatic in_item_t axis_item(input logic [2:0] a, input logic signed [15:0] v,
                                         input logic [31:0] t);
    in_item_t it;
    it = noise_item();
    it.kind = KindAxis;
    it.axis = a;
    it.axis_value = v;
    it.time_ms = t;
    return it;
  endfunction

  function automatic in_item_t scan_item(input logic [31:0] t);
    in_item_t it;
    it = noise_item();
    it.kind = KindScan;
    it.time_ms = t;
    return it;
  endfunction

  // axis readings weighted toward zero, the extremes and the deadzone edge
  function automatic logic signed [15:0] axis_pick();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = -32768;
      2: v = 32767;
      3: v = int'(dz_now);
      4: v = -int'(dz_now);
      5: v = int'(dz_now) + 1;
      6: v = -int'(dz_now) - 1;
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    return 16'(v);
  endfunction

  // offer one item, with random idle cycles ahead of it, and wait until taken
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // setup phase, access phase, then release the bus
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait for every expected event, then let a late scan finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // frames: a few button or axis events with random content, then a scan;
  // now and then a scan is dropped or a noise item slips in
  task automatic random_frames(input int count);
    int          done;
    int          n_ev;
    int          r;
    logic [31:0] t;
    in_item_t    it;
    done = 0;
    while (done < count) begin
      n_ev = $urandom_range(6);
      for (int k = 0; k < n_ev; k++) begin
        clock_ms += $urandom_range(40);
        // an occasional stamp far from now makes durations wrap
        t = ($urandom_range(15) == 0) ? $urandom : clock_ms;
        r = $urandom_range(99);
        if (r < 45) begin
          it = button_item(4'($urandom), 1'($urandom), t);
        end else if (r < 90) begin
          it = axis_item(3'($urandom_range(AxisRightTrig)), axis_pick(), t);
        end else if (r < 95) begin
          it = noise_item();
          it.kind = KindUnused;
        end else begin
          it = axis_item(3'($urandom_range(AxisBadHigh, AxisBadLow)), axis_pick(), t);
        end
        send(it);
        if (r < 90) done++;
      end
      clock_ms += $urandom_range(200, 1);
      if ($urandom_range(19) != 0) begin
        send(scan_item(clock_ms));
        done++;
      end
    end
  endtask

  // receiver: random stalls, or one long hold-off counted here
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with nothing moving on either channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [31:0] dz_next;
    logic [31:0] id_next;
    in_item_t    odd;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with a small deadzone so its edge is easy to hit
    write_reg(AddrDeadzone, 32'(DirDeadzone));
    dz_now = 15'(DirDeadzone);
    write_reg(AddrControllerId, 32'h0000_00a5);

    // scan with every source idle emits nothing
    send(scan_item(32'd0));
    send(button_item(4'd0, 1'b1, 32'd10));
    send(button_item(4'd15, 1'b1, 32'd20));
    send(button_item(4'd15, 1'b0, 32'd30));
    // full-scale negative reading survives any deadzone
    send(axis_item(AxisLeftX, 16'sh8000, 32'd40));
    send(axis_item(AxisLeftY, 16'sh7fff, 32'd41));
    // exactly at the deadzone reads as zero, one above does not
    send(axis_item(AxisRightX, 16'sd1000, 32'd42));
    send(axis_item(AxisRightY, -16'sd1001, 32'd43));
    send(axis_item(AxisLeftTrig, 16'sd1001, 32'd44));
    send(axis_item(AxisRightTrig, -16'sd1000, 32'd45));
    // axis codes past the right trigger and the unused kind are dropped
    send(axis_item(AxisBadLow, 16'sd5000, 32'd46));
    send(axis_item(AxisBadHigh, -16'sd5000, 32'd47));
    odd = noise_item();
    odd.kind = KindUnused;
    send(odd);
    send(scan_item(32'd100));
    // untouched sources: pressed goes to held, released goes to none
    send(scan_item(32'hffff_fff0));
    // stick back to center on both components, trigger let go
    send(axis_item(AxisLeftX, 16'sd0, 32'hffff_fff1));
    send(axis_item(AxisLeftY, 16'sd0, 32'hffff_fff2));
    send(axis_item(AxisLeftTrig, 16'sd0, 32'hffff_fff3));
    send(button_item(4'd0, 1'b0, 32'hffff_ffff));
    send(button_item(4'd7, 1'b1, 32'hffff_fffe));
    send(scan_item(32'd5));
    // durations across the 32-bit wrap
    send(scan_item(32'd6));
    send(scan_item(32'h8000_0000));
    settle();

    // random phases: register extremes first, then random settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          dz_next = 32'd0;
          id_next = 32'd0;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
          dz_next = 32'd32767;
          id_next = 32'd255;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
          dz_next = $urandom_range(32767);
          id_next = $urandom_range(255);
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
          dz_next = $urandom_range(2000);
          id_next = $urandom_range(255);
        end
      endcase
      write_reg(AddrDeadzone, dz_next);
      dz_now = dz_next[14:0];
      write_reg(AddrControllerId, id_next);
      clock_ms = $urandom;
      random_frames(PhaseItems);
      settle();
    end

    // back-pressure: receiver holds off while the sender keeps offering items
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(AddrDeadzone, 32'(DeadzoneRst));
    dz_now = DeadzoneRst;
    write_reg(AddrControllerId, $urandom_range(255));
    clock_ms = $urandom;
    hold_go = 1'b1;
    random_frames(PressureItems);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
